// File: hw/rtl/rapt_pkg.sv
package rapt_pkg;

	// field and register widths
	localparam int ANG_W      = 19;
	localparam int SPEED_W    = 27;
	localparam int GAIN_W     = 31;
	localparam int PERIOD_W   = 17;
	localparam int WORD_W     = 32;
	localparam int FRAC_BITS  = 16;
	localparam int KI_TERM_W  = 34;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 31;

	// angle window: 2*pi in Q16.16 and pi, the negated lower bound of the window
	localparam int ANG_BASE    = 205888;
	localparam int ANG_PERIOD  = 411775;
	localparam int SPEED_LIMIT = 65536000;

	// serial modulo: one compare-subtract per quotient bit
	localparam int    WRAP_W     = 33;
	localparam int    WRAP_STEPS = 14;
	localparam longint WRAP_DIV_L = longint'(ANG_PERIOD) << (WRAP_STEPS - 1);
	localparam logic [WRAP_W-1:0] WRAP_DIV_INIT = WRAP_W'(WRAP_DIV_L);
	localparam logic [WRAP_W-1:0] WRAP_OFFSET   = WRAP_W'(WRAP_DIV_L + longint'(ANG_BASE));

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 2'd2;

	typedef logic signed [ANG_W-1:0]   angle_t;
	typedef logic signed [SPEED_W-1:0] speed_t;
	typedef logic signed [WORD_W-1:0]  word_t;

endpackage

// File: hw/rtl/rotor_angle_pll_tracker_unit.sv
// channel  direction  handshake              payload
// in       input      in_valid / in_ready    measured_angle
// out      output     out_valid / out_ready  angle_estimate, speed_estimate
// cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// an accepted item passes the gain multiply, the period multiply and the angle modulo,
// all bit-serial, and then the output register.
// one item is worked on at a time; the next is accepted once the unit is back in idle.
// reset clears gains to zero, period to one, phase and speed to zero.
// a stalled output holds its result while the next item runs; that item then waits
// in the unit and blocks input until the output register frees.
module rotor_angle_pll_tracker_unit
	import rapt_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  angle_t                measured_angle,
	output logic                  out_valid,
	input  logic                  out_ready,
	output angle_t                angle_estimate,
	output speed_t                speed_estimate,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int ERR_W = ANG_W + 2;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_ERR  = 3'd1;
	localparam logic [2:0] S_MUL1 = 3'd2;
	localparam logic [2:0] S_MUL2 = 3'd3;
	localparam logic [2:0] S_WRAP = 3'd4;
	localparam logic [2:0] S_OUT  = 3'd5;

	logic [2:0]          state_q;
	logic [GAIN_W-1:0]   prop_gain_q;
	logic [GAIN_W-1:0]   integ_gain_q;
	logic [PERIOD_W-1:0] period_q;
	angle_t              phase_q;
	speed_t              speed_q;
	logic signed [ERR_W-1:0] t_q;
	logic                out_valid_q;
	angle_t              angle_out_q;
	speed_t              speed_out_q;

	logic signed [ERR_W-1:0]  err_wide;
	angle_t                   err;
	logic                     kp_done, ki_done, ph_done, sp_done, wrap_done;
	logic signed [ANG_W+GAIN_W-1:0]        kp_prod, ki_prod;
	logic signed [WORD_W+PERIOD_W-1:0]     ph_prod;
	logic signed [KI_TERM_W+PERIOD_W-1:0]  sp_prod;
	word_t                    kp_term, speed_prop, phase_adv, new_phase;
	word_t                    speed_adv, new_speed;
	logic signed [KI_TERM_W-1:0] ki_term;
	speed_t                   speed_next;
	angle_t                   wrap_y;
	logic                     out_free;
	logic                     out_load;

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || out_ready;
	assign out_load  = out_free && (((state_q == S_WRAP) && wrap_done) || (state_q == S_OUT));

	// phase error wrapped into the angle window
	always_comb begin
		if (t_q < 0) begin
			err_wide = t_q + ERR_W'(ANG_PERIOD - ANG_BASE);
		end else if (t_q >= ERR_W'(ANG_PERIOD)) begin
			err_wide = t_q - ERR_W'(ANG_PERIOD + ANG_BASE);
		end else begin
			err_wide = t_q - ERR_W'(ANG_BASE);
		end
		err = err_wide[ANG_W-1:0];
	end

	// proportional path and integrator terms
	assign kp_term    = kp_prod[FRAC_BITS +: WORD_W];
	assign ki_term    = ki_prod[FRAC_BITS +: KI_TERM_W];
	assign speed_prop = WORD_W'(speed_q) + kp_term;
	assign phase_adv  = ph_prod[FRAC_BITS +: WORD_W];
	assign speed_adv  = sp_prod[FRAC_BITS +: WORD_W];
	assign new_phase  = WORD_W'(phase_q) + phase_adv;
	assign new_speed  = WORD_W'(speed_q) + speed_adv;

	// speed clamp
	always_comb begin
		if (new_speed > WORD_W'(SPEED_LIMIT)) begin
			speed_next = SPEED_W'(SPEED_LIMIT);
		end else if (new_speed < WORD_W'(-SPEED_LIMIT)) begin
			speed_next = SPEED_W'(-SPEED_LIMIT);
		end else begin
			speed_next = new_speed[SPEED_W-1:0];
		end
	end

	// gain multiplies, both share the error as multiplicand
	rapt_sermul #(.WA(ANG_W), .WB(GAIN_W)) u_kp_mul (
		.clk(clk), .arst_n(arst_n), .start(state_q == S_ERR),
		.a(err), .b(prop_gain_q), .done(kp_done), .prod(kp_prod)
	);

	rapt_sermul #(.WA(ANG_W), .WB(GAIN_W)) u_ki_mul (
		.clk(clk), .arst_n(arst_n), .start(state_q == S_ERR),
		.a(err), .b(integ_gain_q), .done(ki_done), .prod(ki_prod)
	);

	// period multiplies for the phase advance and the speed increment
	rapt_sermul #(.WA(WORD_W), .WB(PERIOD_W)) u_ph_mul (
		.clk(clk), .arst_n(arst_n), .start((state_q == S_MUL1) && kp_done),
		.a(speed_prop), .b(period_q), .done(ph_done), .prod(ph_prod)
	);

	rapt_sermul #(.WA(KI_TERM_W), .WB(PERIOD_W)) u_sp_mul (
		.clk(clk), .arst_n(arst_n), .start((state_q == S_MUL1) && kp_done),
		.a(ki_term), .b(period_q), .done(sp_done), .prod(sp_prod)
	);

	// new phase into the angle window
	rapt_wrap u_wrap (
		.clk(clk), .arst_n(arst_n), .start((state_q == S_MUL2) && ph_done),
		.x(new_phase), .done(wrap_done), .y(wrap_y)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q  <= '0;
			integ_gain_q <= '0;
			period_q     <= PERIOD_W'(1);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_PROP_GAIN:     prop_gain_q  <= cfg_data[GAIN_W-1:0];
				REG_INTEG_GAIN:    integ_gain_q <= cfg_data[GAIN_W-1:0];
				REG_SAMPLE_PERIOD: period_q     <= cfg_data[PERIOD_W-1:0];
				default: ;
			endcase
		end
	end

	// error offset, registered at acceptance
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			t_q <= ERR_W'(measured_angle) - ERR_W'(phase_q) + ERR_W'(ANG_BASE);
		end
	end

	// sequencer, loop state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= '0;
			speed_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_ERR;
					end
				end
				S_ERR: begin
					state_q <= S_MUL1;
				end
				S_MUL1: begin
					if (kp_done) begin
						state_q <= S_MUL2;
					end
				end
				S_MUL2: begin
					if (ph_done) begin
						speed_q <= speed_next;
						state_q <= S_WRAP;
					end
				end
				S_WRAP: begin
					if (wrap_done) begin
						phase_q <= wrap_y;
						if (out_free) begin
							state_q <= S_IDLE;
						end else begin
							state_q <= S_OUT;
						end
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			angle_out_q <= wrap_y;
			speed_out_q <= speed_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign angle_estimate = angle_out_q;
	assign speed_estimate = speed_out_q;

`ifndef SYNTHESIS
	a_gain_mul_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		(kp_done == ki_done) && (ph_done == sp_done))
		else $error("gain or period multiplies out of step");

	a_speed_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(speed_q <= SPEED_W'(SPEED_LIMIT)) && (speed_q >= SPEED_W'(-SPEED_LIMIT)))
		else $error("speed state beyond clamp");

	a_wrap_window: assert property (@(posedge clk) disable iff (!arst_n)
		wrap_done |-> ((wrap_y >= ANG_W'(-ANG_BASE)) && (wrap_y <= ANG_W'(ANG_BASE - 2))))
		else $error("wrapped phase outside angle window");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_ERR))
		else $error("accepted item did not start processing");
`endif

endmodule

// File: hw/rtl/rapt_sermul.sv
module rapt_sermul
	import rapt_pkg::*;
#(
	parameter int WA = ANG_W,
	parameter int WB = GAIN_W
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [WA-1:0]    a,
	input  logic        [WB-1:0]    b,
	output logic                    done,
	output logic signed [WA+WB-1:0] prod
);

	localparam int CNT_W = $clog2(WB + 1);

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_W-1:0]     cnt_q;
	logic signed [WA-1:0] a_q;
	logic [WB-1:0]        b_q;
	logic signed [WA-1:0] hi_q;
	logic [WB-1:0]        lo_q;
	logic signed [WA:0]   sum;

	// partial sum of the high half and the multiplicand when the multiplier bit is set
	always_comb begin
		sum = {hi_q[WA-1], hi_q};
		if (b_q[0]) begin
			sum = sum + {a_q[WA-1], a_q};
		end
	end

	// control: count multiplier bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(WB);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// datapath: add-shift, one multiplier bit per cycle, lsb first
	always_ff @(posedge clk) begin
		if (start) begin
			a_q  <= a;
			b_q  <= b;
			hi_q <= '0;
			lo_q <= '0;
		end else if (busy_q) begin
			hi_q <= sum[WA:1];
			lo_q <= {sum[0], lo_q[WB-1:1]};
			b_q  <= b_q >> 1;
		end
	end

	assign done = done_q;
	assign prod = {hi_q, lo_q};

endmodule

// File: hw/rtl/rapt_wrap.sv
module rapt_wrap
	import rapt_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  word_t x,
	output logic  done,
	output angle_t y
);

	localparam int CNT_W = $clog2(WRAP_STEPS + 1);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [WRAP_W-1:0] u_q;
	logic [WRAP_W-1:0] d_q;
	logic [ANG_W:0]    y_wide;

	// control: one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(WRAP_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// offset by a multiple of the period plus pi to get a positive dividend,
	// then restoring reduction with a shifting divisor
	always_ff @(posedge clk) begin
		if (start) begin
			u_q <= WRAP_W'(x) + WRAP_OFFSET;
			d_q <= WRAP_DIV_INIT;
		end else if (busy_q) begin
			if (u_q >= d_q) begin
				u_q <= u_q - d_q;
			end
			d_q <= d_q >> 1;
		end
	end

	// remainder back into the angle window
	assign y_wide = {1'b0, u_q[ANG_W-1:0]} - (ANG_W + 1)'(ANG_BASE);
	assign y      = y_wide[ANG_W-1:0];
	assign done   = done_q;

endmodule

// File: test/tb_top.sv
module tb_top
	import rapt_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [CFG_IDX_W-1:0]  REG_UNUSED     = 2'd3;
	localparam logic [CFG_DATA_W-1:0] GAIN_MAX       = {CFG_DATA_W{1'b1}};
	localparam logic [CFG_DATA_W-1:0] PERIOD_WRAPS   = CFG_DATA_W'(32'h0002_0000);
	localparam logic [CFG_DATA_W-1:0] PERIOD_TOP     = CFG_DATA_W'(32'h0001_FFFF);
	localparam logic [CFG_DATA_W-1:0] PERIOD_ONE_SEC = CFG_DATA_W'(32'h0001_0000);
	localparam angle_t RAW_MIN = {1'b1, {(ANG_W-1){1'b0}}};
	localparam angle_t RAW_MAX = {1'b0, {(ANG_W-1){1'b1}}};
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int SETTLE_CYCLES  = 150;
	localparam int RANDOM_PHASES  = 8;
	localparam int PHASE_ITEMS    = 175;

	typedef struct packed {
		angle_t angle;
		speed_t speed;
	} estimate_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	angle_t measured_angle = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	angle_t angle_estimate;
	speed_t speed_estimate;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// tracker model: settings and loop state
	longint kp_model = 0;
	longint ki_model = 0;
	longint period_model = 1;
	int phase_model = 0;
	int speed_model = 0;

	angle_t angle_backlog[$];
	estimate_t pending_estimates[$];
	estimate_t want_est;

	int send_idle_pct = 36;
	int recv_idle_pct = 45;
	int mismatches = 0;
	int samples_sent = 0;
	int estimates_checked = 0;
	int register_writes = 0;
	int quiet_cycles = 0;

	// rotating test angle
	int track_angle = 0;
	int track_step = 0;
	int seg_left = 0;

	rotor_angle_pll_tracker_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.measured_angle (measured_angle),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.angle_estimate (angle_estimate),
		.speed_estimate (speed_estimate),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// reduce into [-pi, pi) modulo 2*pi
	function automatic int wrap_to_window(input longint x);
		longint y;
		y = (x + ANG_BASE) % ANG_PERIOD;
		if (y < 0) begin
			y += ANG_PERIOD;
		end
		return int'(y - ANG_BASE);
	endfunction

	// one loop update for an accepted angle item
	function automatic estimate_t advance_tracker(input angle_t meas);
		int err;
		int kp_term;
		int speed_prop;
		int phase_adv;
		int new_phase;
		int speed_adv;
		int new_speed;
		longint ki_term;
		estimate_t est;
		err = wrap_to_window(longint'(meas) - longint'(phase_model));
		// proportional path drives the phase advance
		kp_term = int'((kp_model * err) >>> FRAC_BITS);
		speed_prop = speed_model + kp_term;
		phase_adv = int'((longint'(speed_prop) * period_model) >>> FRAC_BITS);
		new_phase = phase_model + phase_adv;
		phase_model = wrap_to_window(new_phase);
		// integral path, full-width ki term, then clamp
		ki_term = (ki_model * err) >>> FRAC_BITS;
		speed_adv = int'((ki_term * period_model) >>> FRAC_BITS);
		new_speed = speed_model + speed_adv;
		if (new_speed > SPEED_LIMIT) begin
			new_speed = SPEED_LIMIT;
		end else if (new_speed < -SPEED_LIMIT) begin
			new_speed = -SPEED_LIMIT;
		end
		speed_model = new_speed;
		est.angle = angle_t'(phase_model);
		est.speed = speed_t'(speed_model);
		return est;
	endfunction

	// angle items go out from the backlog
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				pending_estimates.push_back(advance_tracker(measured_angle));
				samples_sent++;
			end
			if (!in_valid || in_ready) begin
				if (angle_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					measured_angle <= angle_backlog.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// estimate items checked against the oldest prediction
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (pending_estimates.size() == 0) begin
					$error("estimate with no prediction: angle %0d speed %0d",
						angle_estimate, speed_estimate);
					mismatches++;
				end else begin
					want_est = pending_estimates.pop_front();
					if (angle_estimate !== want_est.angle) begin
						$error("angle_estimate: expected %0d, got %0d",
							want_est.angle, angle_estimate);
						mismatches++;
					end
					if (speed_estimate !== want_est.speed) begin
						$error("speed_estimate: expected %0d, got %0d",
							want_est.speed, speed_estimate);
						mismatches++;
					end
				end
				estimates_checked++;
			end
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// watchdog on cycles with no item moving on any channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// wait until every angle item is in and every estimate is out
	task automatic drain();
		do begin
			@(negedge clk);
		end while (angle_backlog.size() != 0 || in_valid || pending_estimates.size() != 0);
	endtask

	task automatic write_setting(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_PROP_GAIN: kp_model = longint'(data);
			REG_INTEG_GAIN: ki_model = longint'(data);
			REG_SAMPLE_PERIOD: period_model = longint'(data[PERIOD_W-1:0]);
			default: ;
		endcase
		register_writes++;
	endtask

	task automatic write_loop(input logic [CFG_DATA_W-1:0] kp,
		input logic [CFG_DATA_W-1:0] ki, input logic [CFG_DATA_W-1:0] dt);
		write_setting(REG_PROP_GAIN, kp);
		write_setting(REG_INTEG_GAIN, ki);
		write_setting(REG_SAMPLE_PERIOD, dt);
	endtask

	// pick a loop setting of the given flavor
	task automatic choose_settings(input int flavor);
		logic [CFG_DATA_W-1:0] kp;
		logic [CFG_DATA_W-1:0] ki;
		logic [CFG_DATA_W-1:0] dt;
		case (flavor)
			0: begin
				// realistic tracking loop, short period
				kp = CFG_DATA_W'($urandom_range(32'h0040_0000));
				ki = CFG_DATA_W'($urandom_range(32'h0400_0000));
				dt = CFG_DATA_W'($urandom_range(2000, 1));
			end
			1: begin
				// corners of every register
				kp = $urandom_range(1) ? GAIN_MAX : '0;
				ki = $urandom_range(1) ? GAIN_MAX : '0;
				case ($urandom_range(3))
					0: dt = '0;
					1: dt = CFG_DATA_W'(1);
					2: dt = PERIOD_ONE_SEC;
					default: dt = PERIOD_TOP;
				endcase
			end
			2: begin
				// raw bits, period masked by the block
				kp = CFG_DATA_W'($urandom());
				ki = CFG_DATA_W'($urandom());
				dt = CFG_DATA_W'($urandom());
			end
			default: begin
				// gentle gains, long period
				kp = CFG_DATA_W'($urandom_range(32'h0010_0000));
				ki = CFG_DATA_W'($urandom_range(32'h0040_0000));
				dt = CFG_DATA_W'($urandom_range(65536, 1));
			end
		endcase
		write_loop(kp, ki, dt);
		write_setting(REG_UNUSED, CFG_DATA_W'($urandom()));
	endtask

	// mostly a rotating angle with jitter, the rest raw noise
	task automatic queue_batch(input int count);
		repeat (count) begin
			if (seg_left == 0) begin
				seg_left = $urandom_range(60, 10);
				track_step = int'($urandom_range(40000)) - 20000;
			end
			seg_left--;
			track_angle = wrap_to_window(longint'(track_angle) + track_step);
			if ($urandom_range(99) < 25) begin
				angle_backlog.push_back(angle_t'($urandom()));
			end else begin
				angle_backlog.push_back(angle_t'(track_angle + int'($urandom_range(200)) - 100));
			end
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: zero gains, angles past the window and at its edges
		angle_backlog.push_back(RAW_MIN);
		angle_backlog.push_back(RAW_MAX);
		angle_backlog.push_back(angle_t'(-ANG_BASE));
		angle_backlog.push_back(angle_t'(ANG_BASE - 1));
		drain();

		// one second period, large steps either way
		write_loop(CFG_DATA_W'(32'h0002_0000), CFG_DATA_W'(32'h0064_0000), PERIOD_ONE_SEC);
		angle_backlog.push_back(angle_t'(100000));
		angle_backlog.push_back(angle_t'(-100000));
		angle_backlog.push_back(angle_t'(ANG_BASE - 2));
		angle_backlog.push_back(angle_t'(-ANG_BASE - 1));
		angle_backlog.push_back(angle_t'(1));
		angle_backlog.push_back(angle_t'(-1));
		drain();

		// full gains: product narrowing, add wrap and speed clamp
		write_loop(GAIN_MAX, GAIN_MAX, PERIOD_ONE_SEC);
		angle_backlog.push_back(angle_t'(ANG_BASE - 1));
		angle_backlog.push_back(RAW_MIN);
		angle_backlog.push_back(RAW_MAX);
		angle_backlog.push_back(angle_t'(150000));
		angle_backlog.push_back(angle_t'(-150000));
		drain();

		// period masked to zero freezes advance and integrator
		write_setting(REG_SAMPLE_PERIOD, PERIOD_WRAPS);
		angle_backlog.push_back(angle_t'(50000));
		angle_backlog.push_back(angle_t'(-50000));
		drain();

		// period above one second
		write_setting(REG_SAMPLE_PERIOD, PERIOD_TOP);
		angle_backlog.push_back(angle_t'(0));
		angle_backlog.push_back(angle_t'(30000));
		angle_backlog.push_back(angle_t'(-30000));
		drain();

		// unlisted register is ignored
		write_setting(REG_UNUSED, GAIN_MAX);
		angle_backlog.push_back(angle_t'(12345));
		angle_backlog.push_back(angle_t'(-12345));
		drain();

		// random phases, idling pattern changes at phases 3 and 6
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			if (p == 3) begin
				send_idle_pct = 45;
				recv_idle_pct = 36;
			end else if (p == 6) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			choose_settings(p % 4);
			queue_batch(PHASE_ITEMS);
			drain();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_estimates.size() != 0) begin
			$error("%0d predicted estimates never arrived", pending_estimates.size());
			mismatches++;
		end
		$display("summary: %0d angle items sent, %0d estimates checked", samples_sent,
			estimates_checked);
		$display("summary: %0d register writes across directed and %0d random settings",
			register_writes, RANDOM_PHASES);
		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// File: files.f
hw/rtl/rapt_pkg.sv
hw/rtl/rapt_sermul.sv
hw/rtl/rapt_wrap.sv
hw/rtl/rotor_angle_pll_tracker_unit.sv
test/tb_top.sv
